// File: rtl/bfc_pkg.sv
// Package for the Boolean function completeness checker.
// Holds beat layouts and class flag positions; depends on nothing.
`default_nettype none

package bfc_pkg;

  localparam int ARITY_W     = 3;
  localparam int TABLE_W     = 64;
  localparam int IN_TDATA_W  = 72;  // arity + table, filled to whole bytes
  localparam int OUT_TDATA_W = 8;   // five class flags + verdict, filled
  localparam int NUM_CLASSES = 5;

  // Bit positions of the class flags in the running flags and in m_tdata
  localparam int FLAG_KEEPS_ZERO = 0;
  localparam int FLAG_KEEPS_ONE  = 1;
  localparam int FLAG_SELF_DUAL  = 2;
  localparam int FLAG_MONOTONE   = 3;
  localparam int FLAG_LINEAR     = 4;
  localparam int BIT_SET_COMPLETE = 5;

  typedef logic [NUM_CLASSES-1:0] class_flags_t;

endpackage

`default_nettype wire

// File: rtl/boolean_function_completeness.sv
// Top level of the Boolean function completeness checker (Post criterion).
// Depends on bfc_pkg for beat layouts and class flag positions.
//
// Usage:
//   Slave stream s_*: one beat per Boolean function. s_tdata holds, from the
//   lowest bit up, arity (3 bits) and truth_table (64 bits), then zero fill.
//   s_tlast is last_function: it closes the current set of functions.
//   Master stream m_*: one beat per function. m_tdata holds, from the lowest
//   bit up, keeps_zero, keeps_one, self_dual, monotone, linear, set_complete,
//   then zero fill. m_tlast is set_end, the echo of last_function.
//   set_complete is meaningful only on a set_end beat and reads 0 otherwise.
// Timing:
//   A beat accepted into the input register has its class checks run in
//   combinational logic and lands in the result register once that register
//   is free; m_tvalid rises when the beat lands there.
//   One function per cycle is sustained while m_tready stays high; the rate
//   is set by the single combinational pass between the input and result registers.
// Reset and stalls:
//   rst (synchronous, active high) empties both registers and sets the
//   running class flags to all ones. When the receiver holds m_tready low,
//   the result register holds its beat and the input register still takes
//   one more beat before s_tready drops.
`default_nettype none

module boolean_function_completeness #(
  parameter int MAX_ARITY = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [2:0] arity, [66:3] truth_table, [71:67] zero
  input  wire logic [bfc_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [0] keeps_zero, [1] keeps_one, [2] self_dual, [3] monotone, [4] linear,
  // [5] set_complete, [7:6] zero
  output logic [bfc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  localparam int TW = 1 << MAX_ARITY;   // table bits that matter
  localparam int AW = bfc_pkg::ARITY_W;

  // Input register
  logic          in_valid;
  logic [AW-1:0] in_arity;
  logic [TW-1:0] in_table;
  logic          in_last;

  // Running class flags over the current set
  bfc_pkg::class_flags_t running;

  logic out_free;
  logic load_out;

  assign out_free = !m_tvalid || m_tready;
  assign load_out = in_valid && out_free;
  assign s_tready = !in_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_arity <= s_tdata[AW-1:0];
      in_table <= s_tdata[AW +: TW];
      in_last  <= s_tlast;
    end
  end

  // Class checks on the held function
  logic [AW-1:0]         n;
  logic [MAX_ARITY:0]    size;
  logic [MAX_ARITY-1:0]  top;
  logic [TW-1:0]         span;
  logic [TW-1:0]         t;
  logic [TW-1:0]         rev;
  logic [TW-1:0]         viol;
  logic [TW-1:0]         anf;
  logic [TW-1:0]         lin_ok;
  logic [TW-1:0]         var_mask [MAX_ARITY];
  bfc_pkg::class_flags_t here;
  bfc_pkg::class_flags_t merged;

  always_comb begin
    // Saturate the arity
    if (in_arity > AW'(MAX_ARITY)) n = AW'(MAX_ARITY);
    else                           n = in_arity;

    size = (MAX_ARITY+1)'(1) << n;
    top  = MAX_ARITY'(size - (MAX_ARITY+1)'(1));

    for (int k = 0; k < TW; k++) begin
      span[k] = (k < int'(size));
    end
    for (int i = 0; i < MAX_ARITY; i++) begin
      for (int k = 0; k < TW; k++) begin
        var_mask[i][k] = ((k >> i) & 1) != 0;
      end
    end

    t = in_table & span;

    // Complemented assignment: swap halves for each variable in use
    rev = t;
    for (int i = 0; i < MAX_ARITY; i++) begin
      if (i < int'(n)) begin
        rev = ((rev & var_mask[i]) >> (1 << i)) | ((rev & ~var_mask[i]) << (1 << i));
      end
    end

    // Monotone violations: value drops when a variable goes from 0 to 1
    viol = '0;
    for (int i = 0; i < MAX_ARITY; i++) begin
      if (i < int'(n)) begin
        viol = viol | ((t << (1 << i)) & ~t & var_mask[i]);
      end
    end

    // Zhegalkin coefficients, one butterfly level per variable
    anf = t;
    lin_ok = TW'(1);
    for (int i = 0; i < MAX_ARITY; i++) begin
      if (i < int'(n)) begin
        anf = anf ^ ((anf << (1 << i)) & var_mask[i]);
        lin_ok[1 << i] = 1'b1;
      end
    end

    here[bfc_pkg::FLAG_KEEPS_ZERO] = !t[0];
    here[bfc_pkg::FLAG_KEEPS_ONE]  = t[top];
    here[bfc_pkg::FLAG_SELF_DUAL]  = (n != '0) && (((t ^ rev) & span) == span);
    here[bfc_pkg::FLAG_MONOTONE]   = (viol & span) == '0;
    here[bfc_pkg::FLAG_LINEAR]     = (anf & span & ~lin_ok) == '0;

    merged = running & here;
  end

  // Result register and running flags advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      running  <= '1;
    end else begin
      if (out_free) begin
        m_tvalid <= in_valid;
      end
      if (load_out) begin
        // Restart the set after its closing function
        running <= in_last ? bfc_pkg::class_flags_t'('1) : merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{(bfc_pkg::OUT_TDATA_W-bfc_pkg::NUM_CLASSES-1){1'b0}},
                  in_last && (merged == '0), here};
      m_tlast <= in_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bfc_checker.sv
// Port-level checker for the Boolean function completeness checker.
// Depends on bfc_pkg; bound to boolean_function_completeness below.
`default_nettype none

module bfc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [bfc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                           m_tlast
);

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Verdict only on the beat that closes a set
  a_verdict_on_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[bfc_pkg::BIT_SET_COMPLETE])
    else $error("set_complete raised outside set end");

  // Fill bits stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[bfc_pkg::OUT_TDATA_W-1:bfc_pkg::BIT_SET_COMPLETE+1] == '0)
    else $error("result fill bits not zero");

  // Reset drops any pending result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input stalls only behind a stalled result beat
  a_input_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

endmodule

bind boolean_function_completeness bfc_checker u_bfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
